>>> rtl/three_point_derivative_stream_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the three-point derivative stream core
// Assertions are active in simulation and compile away for synthesis.
// ---------------------------------------------------------------------------
`ifndef THREE_POINT_DERIVATIVE_STREAM_CORE_DEFINES_SVH
`define THREE_POINT_DERIVATIVE_STREAM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TPD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tpd assertion failed");
// next-cycle implication
`define TPD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tpd assertion failed");
`else
`define TPD_ASSERT_NOW(label, ante, cons)
`define TPD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/tpd_pkg.sv
// ---------------------------------------------------------------------------
// tpd_pkg
// Shared types and constants of the three-point derivative stream core.
// ---------------------------------------------------------------------------
`default_nettype none

package tpd_pkg;

   localparam int IDX_W = 16;

   // which stencil a derivative uses
   typedef enum logic [1:0] {
      KIND_FIRST,
      KIND_INNER,
      KIND_LAST
   } kind_type;

endpackage

`default_nettype wire

>>> rtl/tpd_engine.sv
// ---------------------------------------------------------------------------
// tpd_engine
// One derivative per job: serial multiplies, sign fixups and a restoring
// divide, all on one shared add/subtract unit.
// ---------------------------------------------------------------------------
`default_nettype none

`include "three_point_derivative_stream_core_defines.svh"

module tpd_engine #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire tpd_pkg::kind_type            kind,
   input  wire logic signed [DATA_WIDTH-1:0] x0,
   input  wire logic signed [DATA_WIDTH-1:0] x1,
   input  wire logic signed [DATA_WIDTH-1:0] x2,
   input  wire logic signed [DATA_WIDTH-1:0] y0,
   input  wire logic signed [DATA_WIDTH-1:0] y1,
   input  wire logic signed [DATA_WIDTH-1:0] y2,
   output logic                              busy,
   output logic                              done,
   output logic        [DATA_WIDTH-1:0]      slope,
   output logic                              bad
);
   import tpd_pkg::*;

   localparam int W    = DATA_WIDTH;
   localparam int FW   = W + 2;          // factor width
   localparam int NW   = 3 * FW + 1;     // product / numerator width
   localparam int AW   = NW + 2;         // shared adder width
   localparam int DIVN = NW + FRAC_BITS; // divide steps
   localparam int CW   = $clog2(DIVN + 1);
   localparam int QW   = W + 1;
   localparam logic [QW:0]  HALF    = (QW + 1)'(1) << (W - 1);
   localparam logic [W-1:0] SAT_MAX = {1'b0, {(W - 1){1'b1}}};
   localparam logic [W-1:0] SAT_MIN = {1'b1, {(W - 1){1'b0}}};

   typedef enum logic [2:0] {
      E_IDLE, E_MUL, E_COMB, E_ABSN, E_ABSD, E_DIV, E_RND
   } estate_type;

   estate_type state_ff, state_in;
   logic [2:0]             mstep_ff, mstep_in, msel;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic signed [NW-1:0]   mcand_ff, mcand_in;
   logic [FW-1:0]          mplier_ff, mplier_in;
   logic signed [NW-1:0]   p_ff, p_in, t_ff, t_in, n_ff, n_in, d_ff, d_in;
   logic [NW-1:0]          r_ff, r_in;
   logic [DIVN-1:0]        num_ff, num_in;
   logic [QW-1:0]          q_ff, q_in;
   logic                   ovf_ff, ovf_in, neg_ff, neg_in;
   logic [W-1:0]           slope_ff, slope_in;
   logic                   bad_ff, bad_in, done_ff, done_in;

   logic signed [FW-1:0] h1, h2, hh, dy1, dy2, h1_hh, hh_h2;
   logic signed [FW-1:0] a1, a2, a3, b1, b2, b3, my;
   logic signed [NW-1:0] mx;
   logic                 sub_b, coin;

   logic signed [AW-1:0] add_a, add_b, sum;
   logic                 add_sub;
   logic [QW:0]          qr, lim;
   logic                 over;

   // spacings and differences
   assign h1    = FW'(x1) - FW'(x0);
   assign h2    = FW'(x2) - FW'(x1);
   assign hh    = FW'(x2) - FW'(x0);
   assign dy1   = FW'(y1) - FW'(y0);
   assign dy2   = FW'(y2) - FW'(y1);
   assign h1_hh = h1 + hh;
   assign hh_h2 = hh + h2;
   assign coin  = (h1 == '0) || (h2 == '0) || (hh == '0);

   // N = a1*a2*a3 (+/-) b1*b2*b3
   always_comb begin
      a1 = dy1; a2 = h2; a3 = h2; b1 = dy2; b2 = h1; b3 = h1; sub_b = 1'b0;
      case (kind)
         KIND_FIRST: begin
            a3 = h1_hh; sub_b = 1'b1;
         end
         KIND_INNER: begin
            sub_b = 1'b0;
         end
         KIND_LAST: begin
            a1 = dy2; a2 = h1; a3 = hh_h2; b1 = dy1; b2 = h2; b3 = h2; sub_b = 1'b1;
         end
         default: begin
            sub_b = 1'b0;
         end
      endcase
   end

   // next multiply to load; chained steps take the product just finished
   always_comb begin
      case (state_ff)
         E_MUL:   msel = mstep_ff + 3'd1;
         E_COMB:  msel = 3'd4;
         default: msel = 3'd0;
      endcase
      case (msel)
         3'd0:    begin mx = NW'(a1); my = a2; end
         3'd1:    begin mx = NW'(sum); my = a3; end
         3'd2:    begin mx = NW'(b1); my = b2; end
         3'd3:    begin mx = NW'(sum); my = b3; end
         3'd4:    begin mx = NW'(h1); my = h2; end
         default: begin mx = NW'(sum); my = hh; end
      endcase
   end

   // shared add/subtract unit
   always_comb begin
      add_a = '0; add_b = '0; add_sub = 1'b0;
      case (state_ff)
         E_MUL: begin
            add_a   = AW'(p_ff);
            add_b   = mplier_ff[0] ? AW'(mcand_ff) : '0;
            add_sub = (cnt_ff == CW'(FW - 1));
         end
         E_COMB: begin
            add_a = AW'(n_ff); add_b = AW'(t_ff); add_sub = sub_b;
         end
         E_ABSN: begin
            add_b = AW'(n_ff); add_sub = 1'b1;
         end
         E_ABSD: begin
            add_b = AW'(d_ff); add_sub = 1'b1;
         end
         E_DIV: begin
            add_a = AW'({r_ff, num_ff[DIVN-1]}); add_b = AW'(d_ff); add_sub = 1'b1;
         end
         E_RND: begin
            add_a = AW'({r_ff, 1'b0}); add_b = AW'(d_ff); add_sub = 1'b1;
         end
         default: begin
            add_sub = 1'b0;
         end
      endcase
   end
   assign sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);

   // rounding and range check
   assign qr   = (QW + 1)'(q_ff) + (QW + 1)'(!sum[AW-1]);
   assign lim  = HALF - (QW + 1)'(!neg_ff);
   assign over = ovf_ff || (qr > lim);

   always_comb begin
      state_in  = state_ff;  mstep_in = mstep_ff;  cnt_in = cnt_ff;
      mcand_in  = mcand_ff;  mplier_in = mplier_ff;
      p_in = p_ff; t_in = t_ff; n_in = n_ff; d_in = d_ff;
      r_in = r_ff; num_in = num_ff; q_in = q_ff; ovf_in = ovf_ff; neg_in = neg_ff;
      slope_in = slope_ff; bad_in = bad_ff; done_in = 1'b0;
      case (state_ff)
         E_IDLE: begin
            if (start) begin
               mstep_in = 3'd0; mcand_in = mx; mplier_in = my; p_in = '0; cnt_in = '0;
               state_in = E_MUL;
            end
         end
         E_MUL: begin
            p_in      = NW'(sum);
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff == CW'(FW - 1)) begin
               case (mstep_ff)
                  3'd1:    n_in = NW'(sum);
                  3'd3:    t_in = NW'(sum);
                  3'd5:    d_in = NW'(sum);
                  default: p_in = NW'(sum);
               endcase
               if (mstep_ff == 3'd3) begin
                  state_in = E_COMB;
               end else if (mstep_ff == 3'd5) begin
                  state_in = E_ABSN;
               end else begin
                  mstep_in = msel; mcand_in = mx; mplier_in = my; p_in = '0; cnt_in = '0;
               end
            end
         end
         E_COMB: begin
            n_in = NW'(sum);
            mstep_in = msel; mcand_in = mx; mplier_in = my; p_in = '0; cnt_in = '0;
            state_in = E_MUL;
         end
         E_ABSN: begin
            neg_in = n_ff[NW-1] ^ d_ff[NW-1];
            if (coin) begin
               // zero spacing: saturate by the sign of N
               slope_in = n_ff[NW-1] ? SAT_MIN : SAT_MAX;
               bad_in   = 1'b1;
               done_in  = 1'b1;
               state_in = E_IDLE;
            end else begin
               if (n_ff[NW-1]) n_in = NW'(sum);
               state_in = E_ABSD;
            end
         end
         E_ABSD: begin
            if (d_ff[NW-1]) d_in = NW'(sum);
            num_in = DIVN'(n_ff) << FRAC_BITS;
            r_in = '0; q_in = '0; ovf_in = 1'b0; cnt_in = '0;
            state_in = E_DIV;
         end
         E_DIV: begin
            r_in   = sum[AW-1] ? NW'({r_ff, num_ff[DIVN-1]}) : NW'(sum);
            num_in = num_ff << 1;
            q_in   = {q_ff[QW-2:0], !sum[AW-1]};
            ovf_in = ovf_ff | q_ff[QW-1];
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DIVN - 1)) state_in = E_RND;
         end
         E_RND: begin
            if (over) slope_in = neg_ff ? SAT_MIN : SAT_MAX;
            else      slope_in = neg_ff ? W'(-qr) : W'(qr);
            bad_in   = over;
            done_in  = 1'b1;
            state_in = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
         mstep_ff <= 3'd0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         mstep_ff <= mstep_in;
         cnt_ff   <= cnt_in;
      end
      mcand_ff <= mcand_in; mplier_ff <= mplier_in;
      p_ff <= p_in; t_ff <= t_in; n_ff <= n_in; d_ff <= d_in;
      r_ff <= r_in; num_ff <= num_in; q_ff <= q_in; ovf_ff <= ovf_in; neg_ff <= neg_in;
      slope_ff <= slope_in; bad_ff <= bad_in;
   end

   assign busy  = (state_ff != E_IDLE);
   assign done  = done_ff;
   assign slope = slope_ff;
   assign bad   = bad_ff;

   `TPD_ASSERT_NEXT(a_done_idle, done_in, state_ff == E_IDLE)
   `TPD_ASSERT_NOW(a_div_bound, state_ff == E_DIV, cnt_ff < CW'(DIVN))
   `TPD_ASSERT_NOW(a_mul_bound, state_ff == E_MUL, cnt_ff < CW'(FW) && mstep_ff < 3'd6)

endmodule

`default_nettype wire

>>> rtl/three_point_derivative_stream_core.sv
// ---------------------------------------------------------------------------
// three_point_derivative_stream_core
// Streams dy/dx of a run of (x, y) samples on a non-uniform grid.
// ---------------------------------------------------------------------------
// Send a run of (x, y) samples, signed fixed point with FRAC_BITS fraction
// bits, with tlast on the last sample. The third sample yields the
// derivatives of points 0 and 1, each later sample the derivative of the
// previous point, and the last sample also that of itself (tlast on the
// result). A run of one or two samples yields one result: slope 0, index 0,
// error flag set. Zero spacings and out-of-range quotients saturate the
// slope and set the error flag. Every derivative runs through one shared
// add/subtract unit: six serial multiplies, sign fixups and a restoring
// divide of 3*DATA_WIDTH+7+FRAC_BITS steps. A sample is taken only while
// no derivative is in work; the result register lets the next sample in
// while the last result still waits for the sink.
// ---------------------------------------------------------------------------
`default_nettype none

`include "three_point_derivative_stream_core_defines.svh"

module three_point_derivative_stream_core #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   // x_value, y_value
   input  wire logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   input  wire logic                                      req_tlast,   // run_end
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   // slope, point_index
   output logic [((DATA_WIDTH + tpd_pkg::IDX_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                                           rsp_tuser,   // bad_result
   output logic                                           rsp_tlast    // final_result
);
   import tpd_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int RTW = ((W + IDX_W + 7) / 8) * 8;

   typedef enum logic [1:0] { S_IDLE, S_CALC, S_PUT } state_type;

   state_type state_ff, state_in;
   // sample window: 0 oldest, 2 newest
   logic signed [W-1:0] x0_ff, x0_in, x1_ff, x1_in, x2_ff, x2_in;
   logic signed [W-1:0] y0_ff, y0_in, y1_ff, y1_in, y2_ff, y2_in;
   logic [IDX_W-1:0] count_ff, count_in, cjob_ff, cjob_in;
   logic             end_ff, end_in, err_ff, err_in, start_ff, start_in;
   kind_type         kind_ff, kind_in;
   logic             rvalid_ff, rvalid_in, rbad_ff, rbad_in, rfin_ff, rfin_in;
   logic [W-1:0]     rslope_ff, rslope_in;
   logic [IDX_W-1:0] ridx_ff, ridx_in;

   logic             req_beat, rsp_free, more;
   logic             eng_busy, eng_done, eng_bad;
   logic [W-1:0]     eng_slope;

   tpd_engine #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_engine (
      .clock (clock),   .reset (reset),
      .start (start_ff), .kind (kind_ff),
      .x0 (x0_ff), .x1 (x1_ff), .x2 (x2_ff),
      .y0 (y0_ff), .y1 (y1_ff), .y2 (y2_ff),
      .busy (eng_busy), .done (eng_done), .slope (eng_slope), .bad (eng_bad)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_free   = !rvalid_ff || rsp_tready;
   // another derivative for this sample: inner after first, last after inner
   assign more = !err_ff && (kind_ff != KIND_LAST) && ((kind_ff == KIND_FIRST) || end_ff);

   always_comb begin
      state_in = state_ff;
      x0_in = x0_ff; x1_in = x1_ff; x2_in = x2_ff;
      y0_in = y0_ff; y1_in = y1_ff; y2_in = y2_ff;
      count_in = count_ff; cjob_in = cjob_ff; end_in = end_ff; err_in = err_ff;
      kind_in = kind_ff; start_in = 1'b0;
      rvalid_in = rvalid_ff && !rsp_tready;
      rslope_in = rslope_ff; ridx_in = ridx_ff; rbad_in = rbad_ff; rfin_in = rfin_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               x0_in = x1_ff; x1_in = x2_ff; x2_in = req_tdata[W-1:0];
               y0_in = y1_ff; y1_in = y2_ff; y2_in = req_tdata[2*W-1:W];
               cjob_in = count_ff;
               end_in  = req_tlast;
               if (req_tlast)                  count_in = '0;
               else if (count_ff != '1)        count_in = count_ff + IDX_W'(1);
               if (count_ff < IDX_W'(2)) begin
                  // short run ends with one error beat
                  if (req_tlast) begin
                     err_in   = 1'b1;
                     state_in = S_PUT;
                  end
               end else begin
                  kind_in  = (count_ff == IDX_W'(2)) ? KIND_FIRST : KIND_INNER;
                  start_in = 1'b1;
                  state_in = S_CALC;
               end
            end
         end
         S_CALC: begin
            if (eng_done) state_in = S_PUT;
         end
         S_PUT: begin
            if (rsp_free) begin
               rvalid_in = 1'b1;
               if (err_ff) begin
                  rslope_in = '0; ridx_in = '0; rbad_in = 1'b1; rfin_in = 1'b1;
               end else begin
                  rslope_in = eng_slope;
                  rbad_in   = eng_bad;
                  rfin_in   = (kind_ff == KIND_LAST);
                  case (kind_ff)
                     KIND_FIRST: ridx_in = '0;
                     KIND_INNER: ridx_in = cjob_ff - IDX_W'(1);
                     default:    ridx_in = cjob_ff;
                  endcase
               end
               if (more) begin
                  kind_in  = (kind_ff == KIND_FIRST) ? KIND_INNER : KIND_LAST;
                  start_in = 1'b1;
                  state_in = S_CALC;
               end else begin
                  err_in   = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         x0_ff <= '0; x1_ff <= '0; x2_ff <= '0;
         y0_ff <= '0; y1_ff <= '0; y2_ff <= '0;
         count_ff  <= '0;
         err_ff    <= 1'b0;
         start_ff  <= 1'b0;
         rvalid_ff <= 1'b0;
         kind_ff   <= KIND_INNER;
         end_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         x0_ff <= x0_in; x1_ff <= x1_in; x2_ff <= x2_in;
         y0_ff <= y0_in; y1_ff <= y1_in; y2_ff <= y2_in;
         count_ff  <= count_in;
         err_ff    <= err_in;
         start_ff  <= start_in;
         rvalid_ff <= rvalid_in;
         kind_ff   <= kind_in;
         end_ff    <= end_in;
      end
      cjob_ff   <= cjob_in;
      rslope_ff <= rslope_in; ridx_ff <= ridx_in; rbad_ff <= rbad_in; rfin_ff <= rfin_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = RTW'({ridx_ff, rslope_ff});
   assign rsp_tuser  = rbad_ff;
   assign rsp_tlast  = rfin_ff;

   // engine is only kicked when it is free
   `TPD_ASSERT_NOW(a_start_free, start_ff, !eng_busy && state_ff == S_CALC)
   // engine finishes only for a job we are waiting on
   `TPD_ASSERT_NOW(a_done_calc, eng_done, state_ff == S_CALC)
   // the run-closing beat ends the work on that sample
   `TPD_ASSERT_NEXT(a_final_idle, state_ff == S_PUT && rsp_free && (err_ff ||
      kind_ff == KIND_LAST), state_ff == S_IDLE)

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for three_point_derivative_stream_core. Runs of (x, y)
// samples stream in on req_*. An exact wide-integer model of the three-point
// stencils predicts every derivative beat, which is checked on rsp_*. Both
// sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int DW = 32;
   localparam int FB = 16;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 1200;

   typedef logic signed [191:0] swide_type;
   typedef logic [191:0] uwide_type;

   typedef struct packed {
      logic [DW-1:0] x;
      logic [DW-1:0] y;
      logic          last;
   } sample_type;

   typedef struct packed {
      logic [DW-1:0] slope;
      logic [15:0]   idx;
      logic          bad;
      logic          fin;
   } deriv_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;      // x_value, y_value
   logic        req_tlast  = 1'b0;    // run_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // slope, point_index
   logic        rsp_tuser;            // bad_result
   logic        rsp_tlast;            // final_result

   sample_type pending_samples[$];
   deriv_type  expected_derivs[$];
   int         errors = 0;
   int         cycles = 0;

   // predictor state: two previous samples and the run position
   logic signed [DW-1:0] prev2_x = '0, prev1_x = '0, prev2_y = '0, prev1_y = '0;
   int unsigned          run_count = 0;

   three_point_derivative_stream_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly short gaps, a few long ones, none at all in burst stretches
   function automatic int pick_gap(input bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // exact stencil slope, rounded half away from zero, saturated
   function automatic void stencil_slope(input tpd_pkg::kind_type kind,
         input logic signed [DW-1:0] x0, x1, x2, y0, y1, y2,
         output logic [DW-1:0] slope, output logic bad);
      swide_type h1, h2, hh, dy1, dy2, num, den;
      uwide_type an, ad, q, r, lim;
      logic      neg;
      h1  = swide_type'(x1) - swide_type'(x0);
      h2  = swide_type'(x2) - swide_type'(x1);
      hh  = swide_type'(x2) - swide_type'(x0);
      dy1 = swide_type'(y1) - swide_type'(y0);
      dy2 = swide_type'(y2) - swide_type'(y1);
      case (kind)
         tpd_pkg::KIND_FIRST: num = dy1 * h2 * (h1 + hh) - dy2 * h1 * h1;
         tpd_pkg::KIND_INNER: num = dy1 * h2 * h2 + dy2 * h1 * h1;
         default:             num = dy2 * h1 * (hh + h2) - dy1 * h2 * h2;
      endcase
      bad = 1'b0;
      if (h1 == 0 || h2 == 0 || hh == 0) begin
         // coincident abscissas: saturate by the numerator sign
         bad   = 1'b1;
         slope = (num < 0) ? {1'b1, {DW-1{1'b0}}} : {1'b0, {DW-1{1'b1}}};
         return;
      end
      den = h1 * h2 * hh;
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? uwide_type'(-num) : uwide_type'(num);
      ad  = (den < 0) ? uwide_type'(-den) : uwide_type'(den);
      an  = an << FB;
      q   = an / ad;
      r   = an % ad;
      if ((r << 1) >= ad) q = q + 1;
      lim = neg ? (uwide_type'(1) << (DW-1)) : ((uwide_type'(1) << (DW-1)) - 1);
      if (q > lim) begin
         bad   = 1'b1;
         slope = neg ? {1'b1, {DW-1{1'b0}}} : {1'b0, {DW-1{1'b1}}};
      end else begin
         slope = neg ? -q[DW-1:0] : q[DW-1:0];
      end
   endfunction

   // advance the run model by one accepted sample, queue the derivatives
   task automatic predict_derivs(input sample_type s);
      deriv_type d;
      d = '0;
      if (run_count < 2) begin
         if (s.last) begin
            // run too short: one flagged result
            d.bad = 1'b1;
            d.fin = 1'b1;
            expected_derivs.push_back(d);
         end
      end else begin
         if (run_count == 2) begin
            stencil_slope(tpd_pkg::KIND_FIRST, prev2_x, prev1_x, s.x,
                          prev2_y, prev1_y, s.y, d.slope, d.bad);
            d.idx = '0;
            d.fin = 1'b0;
            expected_derivs.push_back(d);
         end
         stencil_slope(tpd_pkg::KIND_INNER, prev2_x, prev1_x, s.x,
                       prev2_y, prev1_y, s.y, d.slope, d.bad);
         d.idx = 16'(run_count - 1);
         d.fin = 1'b0;
         expected_derivs.push_back(d);
         if (s.last) begin
            stencil_slope(tpd_pkg::KIND_LAST, prev2_x, prev1_x, s.x,
                          prev2_y, prev1_y, s.y, d.slope, d.bad);
            d.idx = 16'(run_count);
            d.fin = 1'b1;
            expected_derivs.push_back(d);
         end
      end
      prev2_x = prev1_x;
      prev2_y = prev1_y;
      prev1_x = s.x;
      prev1_y = s.y;
      if (s.last) run_count = 0;
      else if (run_count < 16'hFFFF) run_count = run_count + 1;
   endtask

   // ---------------- driver: req side ----------------
   int req_gap   = 0;
   bit req_burst = 1'b0;

   always @(posedge clock) begin
      sample_type next_s;
      logic       next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_derivs({req_tdata[31:0], req_tdata[63:32], req_tlast});
            void'(pending_samples.pop_front());
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if ($urandom_range(0, 199) == 0) req_burst = ~req_burst;
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
            end else if (pending_samples.size() > 0) begin
               next_s     = pending_samples[0];
               next_valid = 1'b1;
               req_tdata  <= {next_s.y, next_s.x};
               req_tlast  <= next_s.last;
               req_gap    = pick_gap(req_burst);
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // ---------------- monitor: rsp side ----------------
   int rsp_gap   = 0;
   bit rsp_burst = 1'b0;

   always @(posedge clock) begin
      deriv_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[47:32], rsp_tuser, rsp_tlast};
            if (expected_derivs.size() == 0) begin
               $display("%0t: unexpected derivative beat slope=%h idx=%0d bad=%b fin=%b",
                        $time, got.slope, got.idx, got.bad, got.fin);
               errors++;
            end else begin
               want = expected_derivs.pop_front();
               if (got.slope !== want.slope) begin
                  $display("%0t: slope expected %h actual %h", $time, want.slope, got.slope);
                  errors++;
               end
               if (got.idx !== want.idx) begin
                  $display("%0t: point_index expected %0d actual %0d",
                           $time, want.idx, got.idx);
                  errors++;
               end
               if (got.bad !== want.bad) begin
                  $display("%0t: bad_result expected %b actual %b", $time, want.bad, got.bad);
                  errors++;
               end
               if (got.fin !== want.fin) begin
                  $display("%0t: final_result expected %b actual %b",
                           $time, want.fin, got.fin);
                  errors++;
               end
            end
         end
         if ($urandom_range(0, 199) == 0) rsp_burst = ~rsp_burst;
         if (rsp_gap > 0) begin
            rsp_gap = rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap = pick_gap(rsp_burst);
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("three_point_derivative_stream_core verification failed");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic add_sample(input logic [DW-1:0] x, y, input logic last);
      pending_samples.push_back({x, y, last});
   endtask

   // one well-formed run with random spacing and values
   task automatic add_random_run();
      int          len, mode;
      logic [31:0] x, y;
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
      mode = $urandom_range(0, 9);
      x    = $urandom;
      y    = $urandom;
      for (int i = 0; i < len; i++) begin
         if (mode == 0) begin
            x = $urandom;                       // full-range noise
            y = $urandom;
         end else begin
            if ($urandom_range(0, 24) == 0) x = x;   // coincident point
            else if (mode < 4) x = x + $urandom_range(1, 32'h0004_0000);
            else if (mode < 6) x = x - $urandom_range(1, 32'h0000_1000);
            else x = x + $urandom_range(1, 32'h0100_0000) - 32'h0080_0000;
            y = (mode == 9) ? $urandom : y + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         end
         add_sample(x, y, i == len - 1);
      end
   endtask

   initial begin
      // short runs: one and two samples
      add_sample(32'h0001_0000, 32'h0002_0000, 1'b1);
      add_sample(32'h0001_0000, 32'h0002_0000, 1'b0);
      add_sample(32'h0002_0000, 32'h0005_0000, 1'b1);
      // minimal run on y = x^2, uneven spacing
      add_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
      add_sample(32'h0001_0000, 32'h0001_0000, 1'b0);
      add_sample(32'h0003_0000, 32'h0009_0000, 1'b1);
      // coincident x in the middle, then a reversal back to the start
      add_sample(32'h0001_0000, 32'h0003_0000, 1'b0);
      add_sample(32'h0001_0000, 32'hFFFF_0000, 1'b0);
      add_sample(32'h0002_0000, 32'h0000_0000, 1'b0);
      add_sample(32'h0001_0000, 32'h0001_0000, 1'b1);
      // extreme values: steep slope overflows and saturates both ways
      add_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
      add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      add_sample(32'h7FFF_FFFE, 32'h8000_0000, 1'b0);
      add_sample(32'h8000_0001, 32'h7FFF_FFFF, 1'b0);
      add_sample(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
      // tiny spacing with large rise
      add_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
      add_sample(32'h0000_0001, 32'h4000_0000, 1'b0);
      add_sample(32'h0000_0002, 32'hC000_0000, 1'b0);
      add_sample(32'h0000_0003, 32'h0000_0001, 1'b1);
      while (pending_samples.size() < 180) add_random_run();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait (pending_samples.size() == 0 && !req_tvalid);
      wait (expected_derivs.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_derivs.size() == 0)
         $display("three_point_derivative_stream_core verification clean");
      else
         $display("three_point_derivative_stream_core verification failed");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/tpd_pkg.sv
rtl/tpd_engine.sv
rtl/three_point_derivative_stream_core.sv
tb/testbench.sv
